>>> rtl/node_liveness_table_poller_macros.svh
// Assertion macros for the node liveness table poller.
// Depends on nothing; included by the RTL files that assert.
`ifndef NODE_LIVENESS_TABLE_POLLER_MACROS_SVH
`define NODE_LIVENESS_TABLE_POLLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NLT_ASSERT_NOW(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("nlt assertion failed");
`define NLT_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("nlt assertion failed");
`else
`define NLT_ASSERT_NOW(label, clk, rst, a, c)
`define NLT_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

>>> rtl/nlt_pkg.sv
// Shared types and constants of the node liveness table poller.
// Depends on nothing.
package nlt_pkg;
   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam logic [1:0] KIND_HELLO_BC  = 2'd0;
   localparam logic [1:0] KIND_HELLO_ACK = 2'd1;
   localparam logic [1:0] KIND_DATA_ACK  = 2'd2;
   localparam logic [1:0] KIND_POLL      = 2'd3;

   localparam logic [1:0] MSG_HELLO = 2'd0;
   localparam logic [1:0] MSG_DATA  = 2'd1;

   localparam logic [1:0] REG_AGE_TIMEOUT      = 2'd0;
   localparam logic [1:0] REG_RESEND_LIMIT     = 2'd1;
   localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd2;
   localparam logic [1:0] REG_HELLO_INTERVAL   = 2'd3;

   typedef struct packed {
      logic        used;
      logic [7:0]  addr_hi;
      logic [7:0]  addr_lo;
      logic [15:0] age;
      logic [7:0]  polls;
   } entry_type;
endpackage

>>> rtl/nlt_cell.sv
// One table entry of the rotating chain of cells.
// Depends on nlt_pkg.
module nlt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  nlt_pkg::entry_type data_in,
   output nlt_pkg::entry_type data_out
);
   logic        used_ff;
   logic [7:0]  addr_hi_ff;
   logic [7:0]  addr_lo_ff;
   logic [15:0] age_ff;
   logic [7:0]  polls_ff;

   // used bit is control state; address, age and polls need no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (shift) begin
         used_ff <= data_in.used;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         addr_hi_ff <= data_in.addr_hi;
         addr_lo_ff <= data_in.addr_lo;
         age_ff     <= data_in.age;
         polls_ff   <= data_in.polls;
      end
   end

   assign data_out = '{used: used_ff, addr_hi: addr_hi_ff, addr_lo: addr_lo_ff,
                       age: age_ff, polls: polls_ff};
endmodule

>>> rtl/node_liveness_table_poller.sv
// Top level of the node liveness table poller: controller and ring of cells.
// Depends on nlt_pkg, nlt_cell and node_liveness_table_poller_macros.svh.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_ready | op, src_hi, src_lo, msg_kind, sum_ok
//  rsp_    | out       | rsp_valid/rsp_ready | send_kind, dest_hi, dest_lo, last
//  csr_    | in        | csr_we              | csr_index, csr_wdata
//
// A tick in update, test or poll phase rotates the ring once, then closes in a
// final state. A hello or data packet rotates it twice (find, then apply), then
// closes the same way. Other items finish in the accept cycle.
// One item is in work at a time; a new item is taken once the result register
// is empty. A stalled result channel holds the poll rotation in place.
// Synchronous reset empties the table and returns the phase to hello.
`include "node_liveness_table_poller_macros.svh"
module node_liveness_table_poller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_src_hi,
   input  logic [7:0]  req_src_lo,
   input  logic [1:0]  req_msg_kind,
   input  logic        req_sum_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_send_kind,
   output logic [7:0]  rsp_dest_hi,
   output logic [7:0]  rsp_dest_lo,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int N = nlt_pkg::TABLE_ENTRIES;
   localparam int IW = nlt_pkg::IDX_W;

   // controller states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   // rotation modes
   localparam logic [2:0] M_FIND  = 3'd0;
   localparam logic [2:0] M_APPLY = 3'd1;
   localparam logic [2:0] M_AGE   = 3'd2;
   localparam logic [2:0] M_TEST  = 3'd3;
   localparam logic [2:0] M_POLL  = 3'd4;

   // phase codes
   localparam logic [2:0] PH_HELLO  = 3'd1;
   localparam logic [2:0] PH_WAIT   = 3'd2;
   localparam logic [2:0] PH_UPDATE = 3'd3;
   localparam logic [2:0] PH_TEST   = 3'd4;
   localparam logic [2:0] PH_POLL   = 3'd5;

   localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

   // configuration registers
   logic [15:0] age_timeout_ff;
   logic [7:0]  resend_limit_ff;
   logic [7:0]  tps_ff;
   logic [15:0] hello_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_timeout_ff    <= 16'd720;
         resend_limit_ff   <= 8'd5;
         tps_ff            <= 8'd10;
         hello_interval_ff <= 16'd3600;
      end else if (csr_we) begin
         unique case (csr_index)
            nlt_pkg::REG_AGE_TIMEOUT:      age_timeout_ff    <= csr_wdata;
            nlt_pkg::REG_RESEND_LIMIT:     resend_limit_ff   <= csr_wdata[7:0];
            nlt_pkg::REG_TICKS_PER_SECOND: tps_ff            <= csr_wdata[7:0];
            nlt_pkg::REG_HELLO_INTERVAL:   hello_interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   logic [1:0]    st_ff, st_in;
   logic [2:0]    mode_ff, mode_in;
   logic [2:0]    phase_ff, phase_in;
   logic [7:0]    sub_ff, sub_in;
   logic [15:0]   sec_ff, sec_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          match_ff, match_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic          free_ff, free_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;
   logic          any_ff, any_in;
   logic          pend_ff, pend_in;
   logic [7:0]    pend_hi_ff, pend_hi_in;
   logic [7:0]    pend_lo_ff, pend_lo_in;
   logic [7:0]    pkt_hi_ff, pkt_hi_in;
   logic [7:0]    pkt_lo_ff, pkt_lo_in;
   logic          pkt_data_ff, pkt_data_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_hi_ff, rsp_hi_in;
   logic [7:0]  rsp_lo_ff, rsp_lo_in;
   logic        rsp_last_ff, rsp_last_in;

   // ring of cells: cell 0 is the head under the controller, the processed
   // entry goes back in at the tail
   nlt_pkg::entry_type cell_q [N];
   nlt_pkg::entry_type head;
   nlt_pkg::entry_type proc;
   logic               shift;

   for (genvar i = 0; i < N; i++) begin : g_cell
      nlt_pkg::entry_type cell_d;
      if (i == N - 1) begin : g_tail
         assign cell_d = proc;
      end else begin : g_mid
         assign cell_d = cell_q[i+1];
      end
      nlt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .data_in  (cell_d),
         .data_out (cell_q[i])
      );
   end

   assign head = cell_q[0];

   logic        accept;
   logic        out_free;
   logic        push;
   logic [1:0]  push_kind;
   logic [7:0]  push_hi;
   logic [7:0]  push_lo;
   logic        push_last;
   logic [7:0]  sub_sat;
   logic [15:0] sec_sat;
   logic        sec_wrap;
   logic        head_match;
   logic        head_timed;
   logic        need_emit;

   assign req_ready = (st_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign sub_sat  = (sub_ff == 8'hFF) ? sub_ff : sub_ff + 8'd1;
   assign sec_sat  = (sec_ff == 16'hFFFF) ? sec_ff : sec_ff + 16'd1;
   assign sec_wrap = (sec_sat >= hello_interval_ff);

   assign head_match = head.used && (head.addr_hi == pkt_hi_ff) &&
                       (head.addr_lo == pkt_lo_ff);
   assign head_timed = head.used && (head.age >= age_timeout_ff);
   assign need_emit  = (mode_ff == M_APPLY) || ((mode_ff == M_POLL) && pend_ff);

   always_comb begin
      st_in        = st_ff;
      mode_in      = mode_ff;
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      sec_in       = sec_ff;
      cnt_in       = cnt_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      any_in       = any_ff;
      pend_in      = pend_ff;
      pend_hi_in   = pend_hi_ff;
      pend_lo_in   = pend_lo_ff;
      pkt_hi_in    = pkt_hi_ff;
      pkt_lo_in    = pkt_lo_ff;
      pkt_data_in  = pkt_data_ff;
      proc         = head;
      shift        = 1'b0;
      push         = 1'b0;
      push_kind    = nlt_pkg::KIND_POLL;
      push_hi      = 8'd0;
      push_lo      = 8'd0;
      push_last    = 1'b1;

      unique case (st_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               if (!req_op) begin
                  pkt_hi_in   = req_src_hi;
                  pkt_lo_in   = req_src_lo;
                  pkt_data_in = (req_msg_kind == nlt_pkg::MSG_DATA);
                  if (!req_sum_ok) begin
                     // bad checksum: poll the sender straight away
                     push    = 1'b1;
                     push_hi = req_src_hi;
                     push_lo = req_src_lo;
                  end else if (req_msg_kind == nlt_pkg::MSG_HELLO ||
                               req_msg_kind == nlt_pkg::MSG_DATA) begin
                     st_in    = S_SCAN;
                     mode_in  = M_FIND;
                     match_in = 1'b0;
                     free_in  = 1'b0;
                  end
               end else begin
                  sub_in = sub_sat;
                  unique case (phase_ff)
                     PH_HELLO: begin
                        push      = 1'b1;
                        push_kind = nlt_pkg::KIND_HELLO_BC;
                        phase_in  = PH_UPDATE;
                     end
                     PH_WAIT: begin
                        if (sub_sat >= tps_ff) begin
                           sub_in   = 8'd0;
                           sec_in   = sec_wrap ? 16'd0 : sec_sat;
                           phase_in = sec_wrap ? PH_HELLO : PH_UPDATE;
                        end
                     end
                     PH_UPDATE: begin
                        st_in   = S_SCAN;
                        mode_in = M_AGE;
                     end
                     PH_TEST: begin
                        st_in   = S_SCAN;
                        mode_in = M_TEST;
                        any_in  = 1'b0;
                     end
                     PH_POLL: begin
                        st_in   = S_SCAN;
                        mode_in = M_POLL;
                        pend_in = 1'b0;
                     end
                     default: phase_in = PH_HELLO;
                  endcase
               end
            end
         end

         S_SCAN: begin
            shift = 1'b1;
            unique case (mode_ff)
               M_FIND: begin
                  if (!head.used) begin
                     if (!free_ff) begin
                        free_in     = 1'b1;
                        free_idx_in = cnt_ff;
                     end
                  end else if (!match_ff && head_match) begin
                     match_in     = 1'b1;
                     match_idx_in = cnt_ff;
                  end
               end
               M_APPLY: begin
                  if (match_ff && cnt_ff == match_idx_ff) begin
                     proc.age   = 16'd0;
                     proc.polls = 8'd0;
                  end else if (!match_ff && free_ff && cnt_ff == free_idx_ff) begin
                     proc.used    = 1'b1;
                     proc.addr_hi = pkt_hi_ff;
                     proc.addr_lo = pkt_lo_ff;
                     proc.age     = 16'd0;
                     proc.polls   = 8'd0;
                  end
               end
               M_AGE: begin
                  if (head.used && head.age != 16'hFFFF) begin
                     proc.age = head.age + 16'd1;
                  end
               end
               M_TEST: begin
                  if (head_timed) begin
                     any_in = 1'b1;
                  end
               end
               M_POLL: begin
                  if (head_timed) begin
                     if (head.polls >= resend_limit_ff) begin
                        proc.used = 1'b0;
                     end else if (pend_ff && !out_free) begin
                        // hold the ring until the result register drains
                        shift = 1'b0;
                     end else begin
                        if (head.polls != 8'hFF) begin
                           proc.polls = head.polls + 8'd1;
                        end
                        // send the previous poll, keep this one back for last
                        push       = pend_ff;
                        push_hi    = pend_hi_ff;
                        push_lo    = pend_lo_ff;
                        push_last  = 1'b0;
                        pend_in    = 1'b1;
                        pend_hi_in = head.addr_hi;
                        pend_lo_in = head.addr_lo;
                     end
                  end
               end
               default: ;
            endcase

            if (shift) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  cnt_in = '0;
                  if (mode_ff == M_FIND) begin
                     mode_in = M_APPLY;
                  end else begin
                     st_in = S_FIN;
                  end
               end
            end
         end

         S_FIN: begin
            if (!need_emit || out_free) begin
               st_in = S_IDLE;
               push  = need_emit;
               unique case (mode_ff)
                  M_APPLY: begin
                     push_kind = pkt_data_ff ? nlt_pkg::KIND_DATA_ACK :
                                               nlt_pkg::KIND_HELLO_ACK;
                     push_hi   = pkt_hi_ff;
                     push_lo   = pkt_lo_ff;
                  end
                  M_AGE:  phase_in = PH_TEST;
                  M_TEST: phase_in = any_ff ? PH_POLL : PH_WAIT;
                  M_POLL: begin
                     push_hi = pend_hi_ff;
                     push_lo = pend_lo_ff;
                     pend_in = 1'b0;
                     if (sub_ff >= tps_ff) begin
                        sub_in   = 8'd0;
                        sec_in   = sec_wrap ? 16'd0 : sec_sat;
                        phase_in = sec_wrap ? PH_HELLO : PH_UPDATE;
                     end else begin
                        phase_in = PH_TEST;
                     end
                  end
                  default: ;
               endcase
            end
         end

         default: st_in = S_IDLE;
      endcase
   end

   // result register: load on push, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_hi_in    = rsp_hi_ff;
      rsp_lo_in    = rsp_lo_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = push_kind;
         rsp_hi_in    = push_hi;
         rsp_lo_in    = push_lo;
         rsp_last_in  = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         mode_ff      <= M_FIND;
         phase_ff     <= PH_HELLO;
         sub_ff       <= 8'd0;
         sec_ff       <= 16'd0;
         cnt_ff       <= '0;
         match_ff     <= 1'b0;
         free_ff      <= 1'b0;
         any_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         sec_ff       <= sec_in;
         cnt_ff       <= cnt_in;
         match_ff     <= match_in;
         free_ff      <= free_in;
         any_ff       <= any_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      pend_hi_ff   <= pend_hi_in;
      pend_lo_ff   <= pend_lo_in;
      pkt_hi_ff    <= pkt_hi_in;
      pkt_lo_ff    <= pkt_lo_in;
      pkt_data_ff  <= pkt_data_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_hi_ff    <= rsp_hi_in;
      rsp_lo_ff    <= rsp_lo_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_send_kind = rsp_kind_ff;
   assign rsp_dest_hi   = rsp_hi_ff;
   assign rsp_dest_lo   = rsp_lo_ff;
   assign rsp_last      = rsp_last_ff;

   `NLT_ASSERT_NOW(a_busy_not_ready, clock, reset, st_ff != S_IDLE, !req_ready)
   `NLT_ASSERT_NOW(a_pend_in_poll, clock, reset, pend_ff, mode_ff == M_POLL)
   `NLT_ASSERT_NEXT(a_fin_closes, clock, reset, st_ff == S_FIN,
                    st_ff == S_IDLE || st_ff == S_FIN)
endmodule

>>> sim/tb_top.sv
// Self-checking testbench for node_liveness_table_poller.
// Depends on nlt_pkg and the RTL of the block; it runs stand-alone with no files.
`timescale 1ns / 1ps
module tb_top;
   // Run limit: generous, well above the slowest legal run
   localparam int CYCLE_LIMIT = 600000;
   // Longest busy stretch of one item (two ring rotations) plus margin
   localparam int SETTLE_CYCLES = 2 * nlt_pkg::TABLE_ENTRIES + 20;
   localparam int POOL_SIZE = 40;
   localparam int NODES = nlt_pkg::TABLE_ENTRIES;

   // Phase codes of the tick machine, as the block walks them
   typedef enum logic [2:0] {
      ST_HELLO  = 3'd1,
      ST_WAIT   = 3'd2,
      ST_UPDATE = 3'd3,
      ST_TEST   = 3'd4,
      ST_POLL   = 3'd5
   } tick_state_type;

   // Idling patterns of the two channels
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] hi;
      logic [7:0] lo;
      logic       last;
   } frame_type;

   // One row of the directed table; has_exp marks a result typed in by hand
   typedef struct {
      logic       op;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [1:0] msg;
      logic       ok;
      logic       has_exp;
      logic [1:0] exp_kind;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [7:0]  req_src_hi = '0;
   logic [7:0]  req_src_lo = '0;
   logic [1:0]  req_msg_kind = '0;
   logic        req_sum_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_send_kind;
   logic [7:0]  rsp_dest_hi;
   logic [7:0]  rsp_dest_lo;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   node_liveness_table_poller uut (.*);

   // Clock: 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow of the block: configuration, tick machine and node table
   // ---------------------------------------------------------------
   logic [15:0]    cfg_timeout;
   logic [7:0]     cfg_resend;
   logic [7:0]     cfg_tps;
   logic [15:0]    cfg_hello;
   tick_state_type tick_state;
   logic [7:0]     sub_cnt;
   logic [15:0]    sec_cnt;
   logic           node_used  [NODES];
   logic [7:0]     node_hi    [NODES];
   logic [7:0]     node_lo    [NODES];
   logic [15:0]    node_age   [NODES];
   logic [7:0]     node_polls [NODES];

   frame_type   pending_frames[$];   // results still owed by the block

   int unsigned items_taken = 0;
   int unsigned frames_seen = 0;
   int unsigned polls_seen = 0;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;

   idle_mode_type idle_mode = IDLE_NONE;
   int          hold_cnt = 0;     // long receiver hold-off, counted down per cycle
   logic        typed_on = 1'b0;  // directed row with a hand-typed result
   frame_type   typed_frame;

   function automatic void queue_frame(logic [1:0] k, logic [7:0] h, logic [7:0] l);
      frame_type f;
      f.kind = k;
      f.hi = h;
      f.lo = l;
      f.last = 1'b0;
      pending_frames.push_back(f);
   endfunction

   function automatic void shadow_reset();
      cfg_timeout = 16'd720;
      cfg_resend  = 8'd5;
      cfg_tps     = 8'd10;
      cfg_hello   = 16'd3600;
      tick_state  = ST_HELLO;
      sub_cnt     = '0;
      sec_cnt     = '0;
      for (int i = 0; i < NODES; i++) begin
         node_used[i] = 1'b0;
         node_hi[i] = '0;
         node_lo[i] = '0;
         node_age[i] = '0;
         node_polls[i] = '0;
      end
   endfunction

   function automatic void close_second();
      sub_cnt = '0;
      if (sec_cnt != 16'hFFFF) sec_cnt++;
      if (sec_cnt >= cfg_hello) begin
         sec_cnt = '0;
         tick_state = ST_HELLO;
      end else begin
         tick_state = ST_UPDATE;
      end
   endfunction

   function automatic logic stale(int i);
      return node_used[i] && node_age[i] >= cfg_timeout;
   endfunction

   // Advance the shadow by one timer tick and queue the frames it sends
   function automatic void advance_tick();
      logic any;
      any = 1'b0;
      if (sub_cnt != 8'hFF) sub_cnt++;
      case (tick_state)
         ST_HELLO: begin
            queue_frame(nlt_pkg::KIND_HELLO_BC, 8'h00, 8'h00);
            tick_state = ST_UPDATE;
         end
         ST_WAIT: begin
            if (sub_cnt >= cfg_tps) close_second();
         end
         ST_UPDATE: begin
            for (int i = 0; i < NODES; i++)
               if (node_used[i] && node_age[i] != 16'hFFFF) node_age[i]++;
            tick_state = ST_TEST;
         end
         ST_TEST: begin
            for (int i = 0; i < NODES; i++)
               if (stale(i)) any = 1'b1;
            tick_state = any ? ST_POLL : ST_WAIT;
         end
         ST_POLL: begin
            for (int i = 0; i < NODES; i++) begin
               if (stale(i)) begin
                  if (node_polls[i] >= cfg_resend) begin
                     node_used[i] = 1'b0;
                  end else begin
                     if (node_polls[i] != 8'hFF) node_polls[i]++;
                     queue_frame(nlt_pkg::KIND_POLL, node_hi[i], node_lo[i]);
                  end
               end
            end
            if (sub_cnt >= cfg_tps) close_second();
            else tick_state = ST_TEST;
         end
         default: tick_state = ST_HELLO;
      endcase
   endfunction

   // Handle one received packet: poll on bad checksum, ignore other kinds, else ack and refresh the table
   function automatic void absorb_packet(logic [7:0] h, logic [7:0] l, logic [1:0] m,
                                         logic ok);
      int hit;
      int free_slot;
      hit = -1;
      free_slot = -1;
      if (!ok) begin
         queue_frame(nlt_pkg::KIND_POLL, h, l);
         return;
      end
      if (m != nlt_pkg::MSG_HELLO && m != nlt_pkg::MSG_DATA) return;
      for (int i = 0; i < NODES; i++) begin
         if (!node_used[i]) begin
            if (free_slot < 0) free_slot = i;
         end else if (hit < 0 && node_hi[i] == h && node_lo[i] == l) begin
            hit = i;
         end
      end
      if (hit >= 0) begin
         node_age[hit] = '0;
         node_polls[hit] = '0;
      end else if (free_slot >= 0) begin
         node_used[free_slot] = 1'b1;
         node_age[free_slot] = '0;
         node_polls[free_slot] = '0;
         node_hi[free_slot] = h;
         node_lo[free_slot] = l;
      end
      queue_frame(m == nlt_pkg::MSG_HELLO ? nlt_pkg::KIND_HELLO_ACK :
                                            nlt_pkg::KIND_DATA_ACK, h, l);
   endfunction

   // ---------------------------------------------------------------
   // Monitor: predict on every accepted item, check every accepted result
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      int prior_size;
      frame_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycles, pending_frames.size());
         $display("FAIL");
         $finish;
      end
      if (reset) begin
         shadow_reset();
      end else begin
         if (csr_we) begin
            case (csr_index)
               nlt_pkg::REG_AGE_TIMEOUT:      cfg_timeout = csr_wdata;
               nlt_pkg::REG_RESEND_LIMIT:     cfg_resend = csr_wdata[7:0];
               nlt_pkg::REG_TICKS_PER_SECOND: cfg_tps = csr_wdata[7:0];
               nlt_pkg::REG_HELLO_INTERVAL:   cfg_hello = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            items_taken++;
            prior_size = pending_frames.size();
            if (req_op) advance_tick();
            else absorb_packet(req_src_hi, req_src_lo, req_msg_kind, req_sum_ok);
            if (pending_frames.size() > prior_size)
               pending_frames[pending_frames.size() - 1].last = 1'b1;
            // hand-typed rows replace the predicted frame
            if (typed_on) begin
               while (pending_frames.size() > prior_size)
                  void'(pending_frames.pop_back());
               pending_frames.push_back(typed_frame);
            end
         end
         if (rsp_valid && rsp_ready) begin
            frames_seen++;
            if (rsp_send_kind == nlt_pkg::KIND_POLL) polls_seen++;
            if (pending_frames.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result kind %0d dest %02h%02h last %0b",
                           rsp_send_kind, rsp_dest_hi, rsp_dest_lo, rsp_last);
            end else begin
               want = pending_frames.pop_front();
               if (rsp_send_kind !== want.kind || rsp_dest_hi !== want.hi ||
                   rsp_dest_lo !== want.lo || rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("mismatch: expected kind %0d dest %02h%02h last %0b, ",
                            want.kind, want.hi, want.lo, want.last);
                     $display("got kind %0d dest %02h%02h last %0b",
                              rsp_send_kind, rsp_dest_hi, rsp_dest_lo, rsp_last);
                  end
               end
            end
         end
      end
   end

   // Receiver: stall at random, or hold off entirely while hold_cnt runs down
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_ready <= 1'b0;
         hold_cnt <= hold_cnt - 1;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_ready <= ($urandom_range(99) >= 84);
            IDLE_BOTH:     rsp_ready <= ($urandom_range(99) >= 7);
            default:       rsp_ready <= 1'b1;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   logic [7:0] pool_hi[POOL_SIZE];
   logic [7:0] pool_lo[POOL_SIZE];

   // Offer one item; idle gaps first, then hold it until the block takes it
   task automatic offer(logic op, logic [7:0] h, logic [7:0] l, logic [1:0] m, logic ok,
                        logic typed, logic [1:0] tkind);
      int idle_pct;
      idle_pct = (idle_mode == IDLE_SENDER) ? 84 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      typed_on = typed;
      typed_frame.kind = tkind;
      typed_frame.hi = (tkind == nlt_pkg::KIND_HELLO_BC) ? 8'h00 : h;
      typed_frame.lo = (tkind == nlt_pkg::KIND_HELLO_BC) ? 8'h00 : l;
      typed_frame.last = 1'b1;
      req_op <= op;
      req_src_hi <= h;
      req_src_lo <= l;
      req_msg_kind <= m;
      req_sum_ok <= ok;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid, wait for every owed result, then let the block go quiet
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers while the block is idle
   task automatic program_regs(logic [15:0] timeout, logic [7:0] resend, logic [7:0] tps,
                               logic [15:0] hello);
      logic [15:0] vals[4];
      vals = '{timeout, {8'h00, resend}, {8'h00, tps}, hello};
      drain();
      for (int i = 0; i < 4; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= i[1:0];
         csr_wdata <= vals[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly ticks and well-formed packets from a small address pool, some noise
   task automatic random_items(int count, int pool_span);
      int pick;
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         pick = $urandom_range(pool_span - 1);
         if (roll < 50)
            offer(1'b1, 8'($urandom), 8'($urandom), 2'($urandom), 1'($urandom), 1'b0, '0);
         else if (roll < 92)
            offer(1'b0, pool_hi[pick], pool_lo[pick], 2'($urandom_range(1)), 1'b1, 1'b0, '0);
         else
            offer(1'b0, 8'($urandom), 8'($urandom), 2'($urandom), 1'($urandom), 1'b0, '0);
      end
   endtask

   row_type directed[20];

   initial begin
      // directed rows under the reset settings
      directed = '{
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b1, nlt_pkg::KIND_HELLO_BC},  // hello
         '{1'b0, 8'hFF, 8'hFF, 2'd3, 1'b0, 1'b1, nlt_pkg::KIND_POLL},      // bad checksum
         '{1'b0, 8'h00, 8'h00, nlt_pkg::MSG_HELLO, 1'b1, 1'b1, nlt_pkg::KIND_HELLO_ACK},
         '{1'b0, 8'hFF, 8'hFF, nlt_pkg::MSG_DATA, 1'b1, 1'b1, nlt_pkg::KIND_DATA_ACK},
         '{1'b0, 8'hAA, 8'h55, 2'd2, 1'b1, 1'b0, '0},            // other type: silent
         '{1'b0, 8'h55, 8'hAA, 2'd3, 1'b1, 1'b0, '0},
         // known sender
         '{1'b0, 8'h00, 8'h00, nlt_pkg::MSG_DATA, 1'b1, 1'b1, nlt_pkg::KIND_DATA_ACK},
         '{1'b0, 8'h12, 8'h34, nlt_pkg::MSG_HELLO, 1'b0, 1'b1, nlt_pkg::KIND_POLL},
         '{1'b0, 8'h12, 8'h34, nlt_pkg::MSG_HELLO, 1'b1, 1'b1, nlt_pkg::KIND_HELLO_ACK},
         '{1'b1, 8'hFF, 8'hFF, 2'd3, 1'b1, 1'b0, '0},            // update
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},            // test
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},            // tenth tick: second
         '{1'b1, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0, '0},
         '{1'b0, 8'h80, 8'h01, nlt_pkg::MSG_DATA, 1'b1, 1'b1, nlt_pkg::KIND_DATA_ACK}
      };
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_hi[i] = 8'($urandom);
         pool_lo[i] = 8'(i);   // distinct low bytes keep the pool distinct
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         offer(directed[i].op, directed[i].hi, directed[i].lo, directed[i].msg,
               directed[i].ok, directed[i].has_exp, directed[i].exp_kind);
      @(negedge clock);
      typed_on = 1'b0;
      req_valid <= 1'b0;

      // low extremes: every second polls, frees at once
      program_regs(16'd1, 8'd0, 8'd1, 16'd1);
      random_items(10, 8);

      // zero registers: everything times out, every wait or poll tick closes a second
      idle_mode = IDLE_SENDER;
      program_regs(16'd0, 8'd0, 8'd0, 16'd0);
      random_items(10, 8);

      // short timeout with resends; hold the receiver off so the block backs up
      idle_mode = IDLE_RECEIVER;
      program_regs(16'd3, 8'd2, 8'd2, 16'd5);
      @(negedge clock);
      hold_cnt <= 300;
      random_items(20, 12);

      // high extremes: nothing ages out, fill the table past full
      idle_mode = IDLE_BOTH;
      program_regs(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF);
      random_items(5, POOL_SIZE);
      for (int i = 0; i < POOL_SIZE; i++)
         offer(1'b0, pool_hi[i], pool_lo[i], nlt_pkg::MSG_HELLO, 1'b1, 1'b0, '0);

      // mid settings, mixed idling; pause the sender until all results are in
      idle_mode = IDLE_RECEIVER;
      program_regs(16'd2, 8'd1, 8'd1, 16'd3);
      random_items(10, 10);
      drain();
      idle_mode = IDLE_BOTH;
      random_items(10, 10);

      drain();
      $display("covered %0d items and %0d results (%0d polls) over six settings",
               items_taken, frames_seen, polls_seen);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL");
      end
      $finish;
   end
endmodule
